@@ design/mse_pkg.sv @@
// Package with the shared types and constants of the merge sort engine.
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    // Store geometry.
    localparam int DEPTH = 1024;
    localparam int KEY_W = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;

    // Request actions.
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_SORT  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // Response status codes.
    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_FULL      = 2'd1,
        STS_BAD_INDEX = 2'd2
    } t_status;

    // One request.
    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   index;
    } t_req;

    // One response.
    typedef struct packed {
        logic [KEY_W-1:0]   read_value;
        t_status            status;
        logic [CNT_W-1:0]   stored_count;
    } t_rsp;

endpackage

`default_nettype wire

@@ design/merge_sort_engine.sv @@
// Top level of the merge sort engine: key store, merge sequencer and response register.
`timescale 1ns / 1ps
`default_nettype none

// Each request yields exactly one response. Load and clear are answered from the idle state;
// a read passes through a read state for the registered memory read. A sort of n keys runs
// ceil(log2 n) merge passes; each pass sets up each pair of runs in turn and merges it into the
// destination memory, which takes one key a cycle on its single write port. The keys ping-pong
// between two memories, so no copy-back pass is needed. The memories need no clearing after
// reset, so requests are accepted as soon as reset is released. Requests are taken one at a
// time. The request side stalls while a finished response waits in the output register, and
// the next request can be accepted in the cycle that the waiting response leaves.
module merge_sort_engine
    import mse_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire t_req   i_in_req,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_rsp        o_out_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SEG   = 4'b0100,
        ST_MERGE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_bank, n_bank;
    logic               r_rd_ok, n_rd_ok;
    logic [CNT_W-1:0]   r_width, n_width;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_a, n_a;
    logic [CNT_W-1:0]   r_b, n_b;
    logic [CNT_W-1:0]   r_o, n_o;
    logic [CNT_W-1:0]   r_mid, n_mid;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out_rsp, n_out_rsp;

    // Memory ports.
    logic [KEY_W-1:0]   mem0 [DEPTH];
    logic [KEY_W-1:0]   mem1 [DEPTH];
    logic [KEY_W-1:0]   r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;
    logic [IDX_W-1:0]   addr_a, addr_b, wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic               we0, we1;

    logic               accept;
    logic               take_a;
    logic [KEY_W-1:0]   head_a, head_b;
    logic [CNT_W:0]     sum_mid, sum_hi, next_width;
    logic [CNT_W-1:0]   o_next;

    // Both memories: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[wr_addr] <= wr_data;
        end
        r_rd0_a <= mem0[addr_a];
        r_rd0_b <= mem0[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[wr_addr] <= wr_data;
        end
        r_rd1_a <= mem1[addr_a];
        r_rd1_b <= mem1[addr_b];
    end

    // Heads of the two runs come from the bank that holds the current data.
    assign head_a = r_bank ? r_rd1_a : r_rd0_a;
    assign head_b = r_bank ? r_rd1_b : r_rd0_b;

    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // Run bounds for the next pair of runs, clipped to the key count.
    assign sum_mid    = {1'b0, r_lo} + {1'b0, r_width};
    assign sum_hi     = {1'b0, r_lo} + {r_width, 1'b0};
    assign next_width = {r_width, 1'b0};

    // Stable merge choice: the left run wins on equal keys.
    assign take_a = (r_a < r_mid) && ((r_b >= r_hi) || (head_a <= head_b));
    assign o_next = r_o + CNT_W'(1);

    // Sequencer and request handling.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_bank      = r_bank;
        n_rd_ok     = r_rd_ok;
        n_width     = r_width;
        n_lo        = r_lo;
        n_a         = r_a;
        n_b         = r_b;
        n_o         = r_o;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_out_valid = r_out_valid;
        n_out_rsp   = r_out_rsp;
        addr_a      = r_a[IDX_W-1:0];
        addr_b      = r_b[IDX_W-1:0];
        wr_addr     = r_o[IDX_W-1:0];
        wr_data     = head_a;
        we0         = 1'b0;
        we1         = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_req.action)
                        ACT_LOAD: begin
                            n_out_valid          = 1'b1;
                            n_out_rsp.read_value = '0;
                            if (r_count < CNT_W'(DEPTH)) begin
                                wr_addr = r_count[IDX_W-1:0];
                                wr_data = i_in_req.key;
                                we0     = !r_bank;
                                we1     = r_bank;
                                n_count = r_count + CNT_W'(1);
                                n_out_rsp.status = STS_DONE;
                            end else begin
                                n_out_rsp.status = STS_FULL;
                            end
                            n_out_rsp.stored_count = n_count;
                        end
                        ACT_SORT: begin
                            if (r_count <= CNT_W'(1)) begin
                                n_out_valid = 1'b1;
                                n_out_rsp.read_value   = '0;
                                n_out_rsp.status       = STS_DONE;
                                n_out_rsp.stored_count = r_count;
                            end else begin
                                n_width = CNT_W'(1);
                                n_lo    = '0;
                                n_state = ST_SEG;
                            end
                        end
                        ACT_READ: begin
                            addr_a  = i_in_req.index;
                            n_rd_ok = {1'b0, i_in_req.index} < r_count;
                            n_state = ST_READ;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_out_valid = 1'b1;
                            n_out_rsp.read_value   = '0;
                            n_out_rsp.status       = STS_DONE;
                            n_out_rsp.stored_count = '0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_rsp.read_value   = r_rd_ok ? head_a : '0;
                n_out_rsp.status       = r_rd_ok ? STS_DONE : STS_BAD_INDEX;
                n_out_rsp.stored_count = r_count;
                n_state = ST_IDLE;
            end

            // Set up one pair of runs and fetch both heads.
            ST_SEG: begin
                n_mid   = (sum_mid >= {1'b0, r_count}) ? r_count : sum_mid[CNT_W-1:0];
                n_hi    = (sum_hi >= {1'b0, r_count}) ? r_count : sum_hi[CNT_W-1:0];
                n_a     = r_lo;
                n_b     = n_mid;
                n_o     = r_lo;
                addr_a  = r_lo[IDX_W-1:0];
                addr_b  = n_mid[IDX_W-1:0];
                n_state = ST_MERGE;
            end

            // Move one key a cycle into the other bank and refetch the consumed head.
            ST_MERGE: begin
                wr_addr = r_o[IDX_W-1:0];
                wr_data = take_a ? head_a : head_b;
                we0     = r_bank;
                we1     = !r_bank;
                n_o     = o_next;
                if (take_a) begin
                    n_a    = r_a + CNT_W'(1);
                    addr_a = n_a[IDX_W-1:0];
                end else begin
                    n_b    = r_b + CNT_W'(1);
                    addr_b = n_b[IDX_W-1:0];
                end
                if (o_next == r_hi) begin
                    if (r_hi == r_count) begin
                        n_bank  = !r_bank;
                        n_lo    = '0;
                        n_width = next_width[CNT_W-1:0];
                        if (next_width >= {1'b0, r_count}) begin
                            n_out_valid = 1'b1;
                            n_out_rsp.read_value   = '0;
                            n_out_rsp.status       = STS_DONE;
                            n_out_rsp.stored_count = r_count;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_SEG;
                        end
                    end else begin
                        n_lo    = r_hi;
                        n_state = ST_SEG;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rd_ok   <= n_rd_ok;
        r_width   <= n_width;
        r_lo      <= n_lo;
        r_a       <= n_a;
        r_b       <= n_b;
        r_o       <= n_o;
        r_mid     <= n_mid;
        r_hi      <= n_hi;
        r_out_rsp <= n_out_rsp;
    end

endmodule

`default_nettype wire
